FILE: sv/qau_pkg.sv
package qau_pkg;

	localparam int W    = 32;
	localparam int F    = 16;
	localparam int OPW  = 4;
	localparam int SSW  = 2*W + 3;   // sum of four squares of 33-bit values
	localparam int RTW  = W + 2;     // floor square root of that sum
	localparam int NUMW = SSW + 1;   // divider numerator and remainder
	localparam int HSW  = 2*W + 2;   // sum of four products
	localparam int HRW  = HSW - F;   // that sum after the rounding shift
	localparam int QD   = 4;
	localparam int QAW  = $clog2(QD);
	localparam int QCW  = $clog2(QD + 1);

	localparam logic [OPW-1:0] OP_ADD  = OPW'(0);
	localparam logic [OPW-1:0] OP_SUB  = OPW'(1);
	localparam logic [OPW-1:0] OP_MUL  = OPW'(2);
	localparam logic [OPW-1:0] OP_DIV  = OPW'(3);
	localparam logic [OPW-1:0] OP_CONJ = OPW'(4);
	localparam logic [OPW-1:0] OP_NORM = OPW'(5);
	localparam logic [OPW-1:0] OP_NRMZ = OPW'(6);
	localparam logic [OPW-1:0] OP_INV  = OPW'(7);
	localparam logic [OPW-1:0] OP_DOT  = OPW'(8);
	localparam logic [OPW-1:0] OP_DIST = OPW'(9);
	localparam logic [OPW-1:0] OP_CHEB = OPW'(10);

	localparam logic signed [W-1:0] VMAX = {1'b0, {(W-1){1'b1}}};
	localparam logic signed [W-1:0] VMIN = {1'b1, {(W-1){1'b0}}};

	// Hamilton product: part c takes left[j] * right[c ^ j], negated where the bit is set
	localparam logic [15:0] RNEG = 16'h428E;

	typedef logic signed [W-1:0] val_t;
	typedef val_t [3:0] quat_t;
	typedef logic signed [W:0] wval_t;
	typedef wval_t [3:0] wquat_t;

	typedef struct packed {
		logic [OPW-1:0] op;
		quat_t          l;
		quat_t          r;
	} side_t;

	typedef struct packed {
		side_t  side;
		wquat_t sqop;
	} item_t;

	typedef struct packed {
		logic [NUMW-1:0] rem;
		logic [W-1:0]    low;
		logic [W-1:0]    q;
		logic            big;
		logic            neg;
	} dlane_t;

	typedef dlane_t [3:0] dlanes_t;

	function automatic logic rneg(input logic [1:0] c, input logic [1:0] j);
		return RNEG[{c, j}];
	endfunction

	// {clip, value}
	function automatic logic [W:0] sat64(input logic signed [63:0] v);
		logic [W:0] res;
		if (v > $signed({{(64-W){1'b0}}, VMAX}))
			res = {1'b1, VMAX};
		else if (v < $signed({{(64-W){1'b1}}, VMIN}))
			res = {1'b1, VMIN};
		else
			res = {1'b0, v[W-1:0]};
		return res;
	endfunction

endpackage

FILE: sv/qau_in_if.sv
interface qau_in_if;
	logic                     valid;
	logic                     ready;
	logic [qau_pkg::OPW-1:0]  op;
	logic signed [qau_pkg::W-1:0] left_real;
	logic signed [qau_pkg::W-1:0] left_i;
	logic signed [qau_pkg::W-1:0] left_j;
	logic signed [qau_pkg::W-1:0] left_k;
	logic signed [qau_pkg::W-1:0] right_real;
	logic signed [qau_pkg::W-1:0] right_i;
	logic signed [qau_pkg::W-1:0] right_j;
	logic signed [qau_pkg::W-1:0] right_k;

	modport source (output valid, op, left_real, left_i, left_j, left_k,
		right_real, right_i, right_j, right_k, input ready);
	modport sink (input valid, op, left_real, left_i, left_j, left_k,
		right_real, right_i, right_j, right_k, output ready);
endinterface

FILE: sv/qau_out_if.sv
interface qau_out_if;
	logic                         valid;
	logic                         ready;
	logic signed [qau_pkg::W-1:0] out_real;
	logic signed [qau_pkg::W-1:0] out_i;
	logic signed [qau_pkg::W-1:0] out_j;
	logic signed [qau_pkg::W-1:0] out_k;
	logic signed [qau_pkg::W-1:0] out_scalar;
	logic                         zero_divisor;
	logic                         saturated;

	modport source (output valid, out_real, out_i, out_j, out_k, out_scalar,
		zero_divisor, saturated, input ready);
	modport sink (input valid, out_real, out_i, out_j, out_k, out_scalar,
		zero_divisor, saturated, output ready);
endinterface

FILE: sv/qau_front.sv
module qau_front (
	input  logic           clk,
	input  logic           arst_n,
	qau_in_if.sink         req,
	input  logic           full,
	output logic           push,
	output qau_pkg::item_t item
);

	logic           f_vld_s1;
	qau_pkg::item_t f_item_s1;
	qau_pkg::item_t nxt;
	qau_pkg::quat_t l;
	qau_pkg::quat_t r;
	qau_pkg::wquat_t d;

	always_comb begin
		l = {req.left_k, req.left_j, req.left_i, req.left_real};
		r = {req.right_k, req.right_j, req.right_i, req.right_real};
		for (int i = 0; i < 4; i++)
			d[i] = {l[i][qau_pkg::W-1], l[i]} - {r[i][qau_pkg::W-1], r[i]};
		nxt.side.op = req.op;
		nxt.side.l  = l;
		nxt.side.r  = r;
		// squarer source: right for divide, differences for distance, else left
		for (int i = 0; i < 4; i++) begin
			unique case (req.op)
				qau_pkg::OP_DIV:  nxt.sqop[i] = {r[i][qau_pkg::W-1], r[i]};
				qau_pkg::OP_DIST: nxt.sqop[i] = d[i];
				default:          nxt.sqop[i] = {l[i][qau_pkg::W-1], l[i]};
			endcase
		end
	end

	assign req.ready = !f_vld_s1 || !full;
	assign push      = f_vld_s1 && !full;
	assign item      = f_item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			f_vld_s1 <= 1'b0;
		else if (req.ready)
			f_vld_s1 <= req.valid;
	end

	always_ff @(posedge clk) begin
		if (req.ready && req.valid)
			f_item_s1 <= nxt;
	end

endmodule

FILE: sv/qau_queue.sv
module qau_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  qau_pkg::item_t wr_item,
	output logic           full,
	input  logic           pop,
	output logic           rd_vld,
	output qau_pkg::item_t rd_item
);

	qau_pkg::item_t              mem_q [qau_pkg::QD];
	logic [qau_pkg::QAW-1:0]     wptr_q;
	logic [qau_pkg::QAW-1:0]     rptr_q;
	logic [qau_pkg::QCW-1:0]     cnt_q;

	assign full    = cnt_q == qau_pkg::QCW'(qau_pkg::QD);
	assign rd_vld  = cnt_q != '0;
	assign rd_item = mem_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push)
				wptr_q <= wptr_q + qau_pkg::QAW'(1);
			if (pop)
				rptr_q <= rptr_q + qau_pkg::QAW'(1);
			if (push && !pop)
				cnt_q <= cnt_q + qau_pkg::QCW'(1);
			else if (pop && !push)
				cnt_q <= cnt_q - qau_pkg::QCW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wptr_q] <= wr_item;
	end

endmodule

FILE: sv/qau_sqrt.sv
module qau_sqrt (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  logic                      in_vld,
	input  qau_pkg::side_t            in_side,
	input  logic [qau_pkg::SSW-1:0]   in_ss,
	output logic                      out_vld,
	output qau_pkg::side_t            out_side,
	output logic [qau_pkg::SSW-1:0]   out_ss,
	output logic [qau_pkg::RTW-1:0]   out_root
);

	localparam int TW = 2*qau_pkg::RTW + 2;

	logic                    vld_s  [qau_pkg::RTW];
	qau_pkg::side_t          side_s [qau_pkg::RTW];
	logic [qau_pkg::SSW-1:0] ss_s   [qau_pkg::RTW];
	logic [qau_pkg::SSW-1:0] rem_s  [qau_pkg::RTW];
	logic [qau_pkg::RTW-1:0] root_s [qau_pkg::RTW];

	// one root bit per stage, most significant first
	for (genvar k = 0; k < qau_pkg::RTW; k++) begin : g_stage
		localparam int B = qau_pkg::RTW - 1 - k;
		logic                    cv;
		qau_pkg::side_t          cside;
		logic [qau_pkg::SSW-1:0] css;
		logic [qau_pkg::SSW-1:0] crem;
		logic [qau_pkg::RTW-1:0] croot;
		logic [TW-1:0]           trial;
		logic [qau_pkg::SSW-1:0] rem_n;
		logic [qau_pkg::RTW-1:0] root_n;

		if (k == 0) begin : g_first
			assign cv    = in_vld;
			assign cside = in_side;
			assign css   = in_ss;
			assign crem  = in_ss;
			assign croot = '0;
		end else begin : g_next
			assign cv    = vld_s[k-1];
			assign cside = side_s[k-1];
			assign css   = ss_s[k-1];
			assign crem  = rem_s[k-1];
			assign croot = root_s[k-1];
		end

		always_comb begin
			trial = (TW'(croot) << (B + 1)) + (TW'(1) << (2*B));
			if (TW'(crem) >= trial) begin
				rem_n  = crem - trial[qau_pkg::SSW-1:0];
				root_n = croot | (qau_pkg::RTW'(1) << B);
			end else begin
				rem_n  = crem;
				root_n = croot;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				vld_s[k] <= 1'b0;
			else if (en)
				vld_s[k] <= cv;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				side_s[k] <= cside;
				ss_s[k]   <= css;
				rem_s[k]  <= rem_n;
				root_s[k] <= root_n;
			end
		end
	end

	assign out_vld  = vld_s[qau_pkg::RTW-1];
	assign out_side = side_s[qau_pkg::RTW-1];
	assign out_ss   = ss_s[qau_pkg::RTW-1];
	assign out_root = root_s[qau_pkg::RTW-1];

endmodule

FILE: sv/qau_div.sv
module qau_div (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    en,
	input  logic                    in_vld,
	input  qau_pkg::side_t          in_side,
	input  logic [qau_pkg::SSW-1:0] in_ss,
	input  logic [qau_pkg::RTW-1:0] in_root,
	output logic                    out_vld,
	output qau_pkg::side_t          out_side,
	output logic [qau_pkg::RTW-1:0] out_root,
	output logic                    out_zero,
	output qau_pkg::quat_t          out_inv,
	output logic                    out_clip
);

	localparam int W    = qau_pkg::W;
	localparam int NUMW = qau_pkg::NUMW;

	// setup stage
	logic                    vld_s0;
	qau_pkg::side_t          side_s0;
	logic [qau_pkg::RTW-1:0] root_s0;
	logic                    zero_s0;
	logic [qau_pkg::SSW-1:0] den_s0;
	qau_pkg::dlanes_t        ln_s0;

	logic                    norm;
	logic [qau_pkg::SSW-1:0] den;
	qau_pkg::quat_t          src;
	qau_pkg::dlanes_t        ln_init;
	logic [W-1:0]            mag;
	logic [NUMW-1:0]         num;
	logic [NUMW-1:0]         r0;

	always_comb begin
		norm = in_side.op == qau_pkg::OP_NRMZ;
		den  = norm ? qau_pkg::SSW'(in_root) : in_ss;
		src  = (in_side.op == qau_pkg::OP_DIV) ? in_side.r : in_side.l;
		for (int i = 0; i < 4; i++) begin
			mag = src[i][W-1] ? W'(-src[i]) : W'(src[i]);
			// inverse works on the conjugate, normalize keeps every sign
			if (norm || i == 0)
				ln_init[i].neg = src[i][W-1];
			else
				ln_init[i].neg = !src[i][W-1] && (src[i] != '0);
			if (norm)
				num = NUMW'(mag) << qau_pkg::F;
			else
				num = NUMW'(mag) << (2*qau_pkg::F);
			num = num + NUMW'(den >> 1);
			r0  = num >> W;
			ln_init[i].big = r0 >= NUMW'(den);
			ln_init[i].rem = r0;
			ln_init[i].low = num[W-1:0];
			ln_init[i].q   = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s0 <= 1'b0;
		else if (en)
			vld_s0 <= in_vld;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s0 <= in_side;
			root_s0 <= in_root;
			zero_s0 <= in_ss == '0;
			den_s0  <= den;
			ln_s0   <= ln_init;
		end
	end

	// restoring division, one quotient bit per stage on all four lanes
	logic                    vld_s  [W];
	qau_pkg::side_t          side_s [W];
	logic [qau_pkg::RTW-1:0] root_s [W];
	logic                    zero_s [W];
	logic [qau_pkg::SSW-1:0] den_s  [W];
	qau_pkg::dlanes_t        ln_s   [W];

	for (genvar k = 0; k < W; k++) begin : g_stage
		localparam int B = W - 1 - k;
		logic                    cv;
		qau_pkg::side_t          cside;
		logic [qau_pkg::RTW-1:0] croot;
		logic                    czero;
		logic [qau_pkg::SSW-1:0] cden;
		qau_pkg::dlanes_t        cln;
		qau_pkg::dlanes_t        ln_n;
		logic [NUMW-1:0]         t;

		if (k == 0) begin : g_first
			assign cv    = vld_s0;
			assign cside = side_s0;
			assign croot = root_s0;
			assign czero = zero_s0;
			assign cden  = den_s0;
			assign cln   = ln_s0;
		end else begin : g_next
			assign cv    = vld_s[k-1];
			assign cside = side_s[k-1];
			assign croot = root_s[k-1];
			assign czero = zero_s[k-1];
			assign cden  = den_s[k-1];
			assign cln   = ln_s[k-1];
		end

		always_comb begin
			ln_n = cln;
			for (int i = 0; i < 4; i++) begin
				t = {cln[i].rem[NUMW-2:0], cln[i].low[B]};
				if (t >= NUMW'(cden)) begin
					ln_n[i].rem  = t - NUMW'(cden);
					ln_n[i].q[B] = 1'b1;
				end else begin
					ln_n[i].rem = t;
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				vld_s[k] <= 1'b0;
			else if (en)
				vld_s[k] <= cv;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				side_s[k] <= cside;
				root_s[k] <= croot;
				zero_s[k] <= czero;
				den_s[k]  <= cden;
				ln_s[k]   <= ln_n;
			end
		end
	end

	// sign and saturate
	logic                    vld_sx;
	qau_pkg::side_t          side_sx;
	logic [qau_pkg::RTW-1:0] root_sx;
	logic                    zero_sx;
	qau_pkg::quat_t          inv_sx;
	logic                    clip_sx;

	qau_pkg::dlanes_t        lf;
	qau_pkg::quat_t          inv_n;
	logic                    clip_n;

	always_comb begin
		lf     = ln_s[W-1];
		clip_n = 1'b0;
		for (int i = 0; i < 4; i++) begin
			if (lf[i].big) begin
				clip_n   = 1'b1;
				inv_n[i] = lf[i].neg ? qau_pkg::VMIN : qau_pkg::VMAX;
			end else if (!lf[i].neg) begin
				if (lf[i].q[W-1]) begin
					clip_n   = 1'b1;
					inv_n[i] = qau_pkg::VMAX;
				end else begin
					inv_n[i] = lf[i].q;
				end
			end else if ({1'b0, lf[i].q} > ((W+1)'(1) << (W-1))) begin
				clip_n   = 1'b1;
				inv_n[i] = qau_pkg::VMIN;
			end else begin
				inv_n[i] = ~lf[i].q + W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_sx <= 1'b0;
		else if (en)
			vld_sx <= vld_s[W-1];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_sx <= side_s[W-1];
			root_sx <= root_s[W-1];
			zero_sx <= zero_s[W-1];
			inv_sx  <= inv_n;
			clip_sx <= clip_n;
		end
	end

	assign out_vld  = vld_sx;
	assign out_side = side_sx;
	assign out_root = root_sx;
	assign out_zero = zero_sx;
	assign out_inv  = inv_sx;
	assign out_clip = clip_sx;

endmodule

FILE: sv/qau_back.sv
module qau_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           rd_vld,
	input  qau_pkg::item_t rd_item,
	output logic           pop,
	qau_out_if.source      rsp
);

	localparam int W   = qau_pkg::W;
	localparam int HSW = qau_pkg::HSW;
	localparam int HRW = qau_pkg::HRW;

	logic ovld_q;
	logic en;

	assign en  = !ovld_q || rsp.ready;
	assign pop = en && rd_vld;

	// squares
	logic                vld_s1;
	qau_pkg::side_t      side_s1;
	logic [2*W+1:0]      sq_s1 [4];
	logic signed [2*W+1:0] sq_n [4];

	always_comb begin
		for (int i = 0; i < 4; i++)
			sq_n[i] = $signed(rd_item.sqop[i]) * $signed(rd_item.sqop[i]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s1 <= 1'b0;
		else if (en)
			vld_s1 <= rd_vld;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s1 <= rd_item.side;
			for (int i = 0; i < 4; i++)
				sq_s1[i] <= sq_n[i];
		end
	end

	// sum of squares
	logic                    vld_s2;
	qau_pkg::side_t          side_s2;
	logic [qau_pkg::SSW-1:0] ss_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s2 <= 1'b0;
		else if (en)
			vld_s2 <= vld_s1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s2 <= side_s1;
			ss_s2   <= qau_pkg::SSW'(sq_s1[0]) + qau_pkg::SSW'(sq_s1[1])
				+ qau_pkg::SSW'(sq_s1[2]) + qau_pkg::SSW'(sq_s1[3]);
		end
	end

	logic                    sq_vld;
	qau_pkg::side_t          sq_side;
	logic [qau_pkg::SSW-1:0] sq_ss;
	logic [qau_pkg::RTW-1:0] sq_root;

	qau_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (vld_s2),
		.in_side  (side_s2),
		.in_ss    (ss_s2),
		.out_vld  (sq_vld),
		.out_side (sq_side),
		.out_ss   (sq_ss),
		.out_root (sq_root)
	);

	logic                    dv_vld;
	qau_pkg::side_t          dv_side;
	logic [qau_pkg::RTW-1:0] dv_root;
	logic                    dv_zero;
	qau_pkg::quat_t          dv_inv;
	logic                    dv_clip;

	qau_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (sq_vld),
		.in_side  (sq_side),
		.in_ss    (sq_ss),
		.in_root  (sq_root),
		.out_vld  (dv_vld),
		.out_side (dv_side),
		.out_root (dv_root),
		.out_zero (dv_zero),
		.out_inv  (dv_inv),
		.out_clip (dv_clip)
	);

	// Hamilton products against right, or against the inverse of right for divide
	logic                    vld_s3;
	qau_pkg::side_t          side_s3;
	logic [qau_pkg::RTW-1:0] root_s3;
	logic                    zero_s3;
	qau_pkg::quat_t          inv_s3;
	logic                    clip_s3;
	logic signed [2*W-1:0]   prod_s3 [4][4];
	qau_pkg::quat_t          rr;

	assign rr = (dv_side.op == qau_pkg::OP_DIV) ? dv_inv : dv_side.r;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s3 <= 1'b0;
		else if (en)
			vld_s3 <= dv_vld;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s3 <= dv_side;
			root_s3 <= dv_root;
			zero_s3 <= dv_zero;
			inv_s3  <= dv_inv;
			clip_s3 <= dv_clip;
			for (int c = 0; c < 4; c++)
				for (int j = 0; j < 4; j++)
					prod_s3[c][j] <= $signed(dv_side.l[j]) * $signed(rr[2'(c ^ j)]);
		end
	end

	// signed sums, round half up, drop the extra fraction bits
	logic                    vld_s4;
	qau_pkg::side_t          side_s4;
	logic [qau_pkg::RTW-1:0] root_s4;
	logic                    zero_s4;
	qau_pkg::quat_t          inv_s4;
	logic                    clip_s4;
	logic signed [HRW-1:0]   hq_s4 [4];
	logic signed [HRW-1:0]   hdot_s4;
	logic [HSW-1:0]          hs_n [4];
	logic [HSW-1:0]          hd_n;
	logic [HSW-1:0]          pe;

	always_comb begin
		hd_n = HSW'(1) << (qau_pkg::F - 1);
		for (int c = 0; c < 4; c++) begin
			hs_n[c] = HSW'(1) << (qau_pkg::F - 1);
			for (int j = 0; j < 4; j++) begin
				pe = {{(HSW-2*W){prod_s3[c][j][2*W-1]}}, prod_s3[c][j]};
				if (qau_pkg::rneg(2'(c), 2'(j)))
					hs_n[c] = hs_n[c] - pe;
				else
					hs_n[c] = hs_n[c] + pe;
			end
		end
		for (int j = 0; j < 4; j++)
			hd_n = hd_n + {{(HSW-2*W){prod_s3[0][j][2*W-1]}}, prod_s3[0][j]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s4 <= 1'b0;
		else if (en)
			vld_s4 <= vld_s3;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s4 <= side_s3;
			root_s4 <= root_s3;
			zero_s4 <= zero_s3;
			inv_s4  <= inv_s3;
			clip_s4 <= clip_s3;
			for (int c = 0; c < 4; c++)
				hq_s4[c] <= hs_n[c][HSW-1:qau_pkg::F];
			hdot_s4 <= hd_n[HSW-1:qau_pkg::F];
		end
	end

	// result select and output register
	qau_pkg::quat_t          oq_q;
	logic signed [W-1:0]     osc_q;
	logic                    ozd_q;
	logic                    osat_q;
	logic [qau_pkg::OPW-1:0] oop_q;

	qau_pkg::quat_t          nq;
	logic signed [W-1:0]     nsc;
	logic                    nzd;
	logic                    nclip;
	logic [W:0]              s_add  [4];
	logic [W:0]              s_sub  [4];
	logic [W:0]              s_conj [4];
	logic [W:0]              s_ham  [4];
	logic [W:0]              s_root;
	logic [W:0]              s_dot;
	logic [W:0]              s_cheb;
	logic [W:0]              dsum;
	logic [W:0]              ddif;
	logic [W:0]              dabs;
	logic [W:0]              dmax;
	logic [W:0]              neg_l;
	logic                    hclip;
	qau_pkg::quat_t          hval;
	qau_pkg::quat_t          l4;
	qau_pkg::quat_t          r4;

	always_comb begin
		l4    = side_s4.l;
		r4    = side_s4.r;
		dmax  = '0;
		hclip = 1'b0;
		for (int i = 0; i < 4; i++) begin
			dsum  = {l4[i][W-1], l4[i]} + {r4[i][W-1], r4[i]};
			ddif  = {l4[i][W-1], l4[i]} - {r4[i][W-1], r4[i]};
			neg_l = -{l4[i][W-1], l4[i]};
			dabs  = ddif[W] ? -ddif : ddif;
			if (dabs > dmax)
				dmax = dabs;
			s_add[i]  = qau_pkg::sat64({{(63-W){dsum[W]}}, dsum});
			s_sub[i]  = qau_pkg::sat64({{(63-W){ddif[W]}}, ddif});
			s_conj[i] = (i == 0) ? {1'b0, l4[i]}
				: qau_pkg::sat64({{(63-W){neg_l[W]}}, neg_l});
			s_ham[i]  = qau_pkg::sat64({{(64-HRW){hq_s4[i][HRW-1]}}, hq_s4[i]});
			hval[i]   = s_ham[i][W-1:0];
			hclip     = hclip | s_ham[i][W];
		end
		s_root = qau_pkg::sat64({{(64-qau_pkg::RTW){1'b0}}, root_s4});
		s_dot  = qau_pkg::sat64({{(64-HRW){hdot_s4[HRW-1]}}, hdot_s4});
		s_cheb = qau_pkg::sat64({{(63-W){1'b0}}, dmax});

		nq    = '0;
		nsc   = '0;
		nzd   = 1'b0;
		nclip = 1'b0;
		unique case (side_s4.op)
			qau_pkg::OP_ADD: begin
				for (int i = 0; i < 4; i++) begin
					nq[i] = s_add[i][W-1:0];
					nclip = nclip | s_add[i][W];
				end
			end
			qau_pkg::OP_SUB: begin
				for (int i = 0; i < 4; i++) begin
					nq[i] = s_sub[i][W-1:0];
					nclip = nclip | s_sub[i][W];
				end
			end
			qau_pkg::OP_MUL: begin
				nq    = hval;
				nclip = hclip;
			end
			qau_pkg::OP_DIV: begin
				nzd = zero_s4;
				if (!zero_s4) begin
					nq    = hval;
					nclip = hclip | clip_s4;
				end
			end
			qau_pkg::OP_CONJ: begin
				for (int i = 0; i < 4; i++) begin
					nq[i] = s_conj[i][W-1:0];
					nclip = nclip | s_conj[i][W];
				end
			end
			qau_pkg::OP_NORM, qau_pkg::OP_DIST: begin
				nsc   = s_root[W-1:0];
				nclip = s_root[W];
			end
			qau_pkg::OP_NRMZ, qau_pkg::OP_INV: begin
				nzd = zero_s4;
				if (!zero_s4) begin
					nq    = inv_s4;
					nclip = clip_s4;
				end
			end
			qau_pkg::OP_DOT: begin
				nsc   = s_dot[W-1:0];
				nclip = s_dot[W];
			end
			qau_pkg::OP_CHEB: begin
				nsc   = s_cheb[W-1:0];
				nclip = s_cheb[W];
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			ovld_q <= 1'b0;
		else if (en)
			ovld_q <= vld_s4;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			oq_q   <= nq;
			osc_q  <= nsc;
			ozd_q  <= nzd;
			osat_q <= nclip;
			oop_q  <= side_s4.op;
		end
	end

	assign rsp.valid        = ovld_q;
	assign rsp.out_real     = oq_q[0];
	assign rsp.out_i        = oq_q[1];
	assign rsp.out_j        = oq_q[2];
	assign rsp.out_k        = oq_q[3];
	assign rsp.out_scalar   = osc_q;
	assign rsp.zero_divisor = ozd_q;
	assign rsp.saturated    = osat_q;

	a_zd_ops: assert property (@(posedge clk) disable iff (!arst_n)
		ovld_q && ozd_q |-> (oop_q == qau_pkg::OP_DIV || oop_q == qau_pkg::OP_NRMZ
			|| oop_q == qau_pkg::OP_INV))
		else $error("zero divisor flagged on an op without a division");

	a_zd_nosat: assert property (@(posedge clk) disable iff (!arst_n)
		ovld_q && ozd_q |-> !osat_q && oq_q == '0)
		else $error("zero divisor beat carries a clipped or nonzero quaternion");

	a_scalar_ops: assert property (@(posedge clk) disable iff (!arst_n)
		ovld_q && osc_q != '0 |-> (oop_q == qau_pkg::OP_NORM || oop_q == qau_pkg::OP_DOT
			|| oop_q == qau_pkg::OP_DIST || oop_q == qau_pkg::OP_CHEB))
		else $error("scalar result on a quaternion op");

endmodule

FILE: sv/quaternion_arithmetic_unit.sv
// Every op takes the same path, through the 34-stage square root and the divider.
// Throughput: one beat per cycle unless rsp stalls; both are fully pipelined,
// one result bit per stage (32 divider bit stages between setup and sign stages).
// A four-entry queue parts the decode stage from the arithmetic pipeline.
// Reset: arst_n clears the valid bits and queue pointers at once; no data is cleared.
module quaternion_arithmetic_unit (
	input  logic      clk,
	input  logic      arst_n,
	qau_in_if.sink    req,
	qau_out_if.source rsp
);

	logic           full;
	logic           push;
	logic           pop;
	logic           rd_vld;
	qau_pkg::item_t push_item;
	qau_pkg::item_t rd_item;

	qau_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.full   (full),
		.push   (push),
		.item   (push_item)
	);

	qau_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_item (push_item),
		.full    (full),
		.pop     (pop),
		.rd_vld  (rd_vld),
		.rd_item (rd_item)
	);

	qau_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_vld  (rd_vld),
		.rd_item (rd_item),
		.pop     (pop),
		.rsp     (rsp)
	);

endmodule

FILE: bench/testbench.sv
`timescale 1ns / 1ps

module testbench;

	localparam int   ONE_Q      = 1 << qau_pkg::F;
	localparam int   SETTLE     = 100;
	localparam int   STALL_HOLD = 400;
	localparam int   DOG_LIMIT  = 3000;
	localparam logic [qau_pkg::OPW-1:0] OP_BAD_LO = qau_pkg::OP_CHEB + 1'b1;
	localparam logic [qau_pkg::OPW-1:0] OP_BAD_HI = '1;

	typedef logic signed [127:0] acc_t;
	typedef acc_t  acc4_t[4];
	typedef qau_pkg::val_t part4_t[4];

	typedef struct {
		qau_pkg::val_t re, vi, vj, vk, sc;
		logic zd, clip;
	} qres_t;

	logic clk;
	logic arst_n;

	qau_in_if  req_bus();
	qau_out_if rsp_bus();

	quaternion_arithmetic_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_bus),
		.rsp(rsp_bus)
	);

	qres_t pending_results[$];
	int    err_count;
	int    tx_idle_pct;
	int    rx_idle_pct;
	int    rx_hold_cycles;
	int    dog_count;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// ---------------- arithmetic model ----------------

	function automatic qau_pkg::val_t clamp(input acc_t v, inout logic clip);
		if (v > acc_t'(qau_pkg::VMAX)) begin
			clip = 1'b1;
			return qau_pkg::VMAX;
		end
		if (v < acc_t'(qau_pkg::VMIN)) begin
			clip = 1'b1;
			return qau_pkg::VMIN;
		end
		return qau_pkg::val_t'(v);
	endfunction

	function automatic acc_t floor_sqrt(input acc_t n);
		acc_t res;
		acc_t b;
		res = 0;
		b = acc_t'(1) << 124;
		while (b != 0 && b > n)
			b = b >> 2;
		while (b != 0) begin
			if (n >= res + b) begin
				n = n - (res + b);
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
			b = b >> 2;
		end
		return res;
	endfunction

	function automatic acc_t sum_squares(input acc4_t v);
		acc_t s;
		s = 0;
		for (int i = 0; i < 4; i++)
			s += v[i] * v[i];
		return s;
	endfunction

	// magnitudes rounded half away from zero, sign put back after
	function automatic qau_pkg::val_t round_div(input acc_t x, input int k, input acc_t den,
			inout logic clip);
		acc_t m;
		acc_t qv;
		m = (x < 0) ? -x : x;
		qv = ((m << k) + (den >> 1)) / den;
		if (x < 0)
			qv = -qv;
		return clamp(qv, clip);
	endfunction

	function automatic acc_t round_shift(input acc_t s);
		return (s + (acc_t'(1) << (qau_pkg::F - 1))) >>> qau_pkg::F;
	endfunction

	function automatic void hamilton(input acc4_t a, input acc4_t b, output part4_t o,
			inout logic clip);
		acc_t s;
		for (int c = 0; c < 4; c++) begin
			s = 0;
			for (int j = 0; j < 4; j++) begin
				if (qau_pkg::RNEG[c*4 + j])
					s -= a[j] * b[c ^ j];
				else
					s += a[j] * b[c ^ j];
			end
			o[c] = clamp(round_shift(s), clip);
		end
	endfunction

	function automatic qres_t quat_result(input logic [qau_pkg::OPW-1:0] op,
			input part4_t lq, input part4_t rq);
		qres_t  res;
		acc4_t  l, r, d, inv;
		part4_t o, iv;
		acc_t   s, nq, m;
		logic   clip;
		clip = 1'b0;
		o = '{default: '0};
		res.sc = '0;
		res.zd = 1'b0;
		for (int i = 0; i < 4; i++) begin
			l[i] = lq[i];
			r[i] = rq[i];
			d[i] = l[i] - r[i];
		end
		case (op)
			qau_pkg::OP_ADD: for (int i = 0; i < 4; i++) o[i] = clamp(l[i] + r[i], clip);
			qau_pkg::OP_SUB: for (int i = 0; i < 4; i++) o[i] = clamp(d[i], clip);
			qau_pkg::OP_MUL: hamilton(l, r, o, clip);
			qau_pkg::OP_DIV: begin
				s = sum_squares(r);
				if (s == 0) begin
					res.zd = 1'b1;
				end else begin
					for (int i = 0; i < 4; i++) begin
						iv[i] = round_div(i == 0 ? r[0] : -r[i], 2*qau_pkg::F, s, clip);
						inv[i] = iv[i];
					end
					hamilton(l, inv, o, clip);
				end
			end
			qau_pkg::OP_CONJ:
				for (int i = 0; i < 4; i++) o[i] = clamp(i == 0 ? l[0] : -l[i], clip);
			qau_pkg::OP_NORM: res.sc = clamp(floor_sqrt(sum_squares(l)), clip);
			qau_pkg::OP_NRMZ: begin
				s = sum_squares(l);
				if (s == 0) begin
					res.zd = 1'b1;
				end else begin
					nq = floor_sqrt(s);
					for (int i = 0; i < 4; i++) o[i] = round_div(l[i], qau_pkg::F, nq, clip);
				end
			end
			qau_pkg::OP_INV: begin
				s = sum_squares(l);
				if (s == 0)
					res.zd = 1'b1;
				else
					for (int i = 0; i < 4; i++)
						o[i] = round_div(i == 0 ? l[0] : -l[i], 2*qau_pkg::F, s, clip);
			end
			qau_pkg::OP_DOT: begin
				s = 0;
				for (int i = 0; i < 4; i++) s += l[i] * r[i];
				res.sc = clamp(round_shift(s), clip);
			end
			qau_pkg::OP_DIST: res.sc = clamp(floor_sqrt(sum_squares(d)), clip);
			qau_pkg::OP_CHEB: begin
				m = 0;
				for (int i = 0; i < 4; i++) begin
					s = (d[i] < 0) ? -d[i] : d[i];
					if (s > m) m = s;
				end
				res.sc = clamp(m, clip);
			end
			default: ;
		endcase
		res.re = o[0];
		res.vi = o[1];
		res.vj = o[2];
		res.vk = o[3];
		res.clip = clip;
		return res;
	endfunction

	// ---------------- request side ----------------

	function automatic int pick_gap(input int pct);
		if ($urandom_range(0, 99) >= pct)
			return 0;
		if ($urandom_range(0, 9) == 0)
			return $urandom_range(10, 40);
		return $urandom_range(1, 3);
	endfunction

	task automatic send_beat(input logic [qau_pkg::OPW-1:0] op, input part4_t lq,
			input part4_t rq);
		int gap;
		req_bus.valid      <= 1'b1;
		req_bus.op         <= op;
		req_bus.left_real  <= lq[0];
		req_bus.left_i     <= lq[1];
		req_bus.left_j     <= lq[2];
		req_bus.left_k     <= lq[3];
		req_bus.right_real <= rq[0];
		req_bus.right_i    <= rq[1];
		req_bus.right_j    <= rq[2];
		req_bus.right_k    <= rq[3];
		do @(posedge clk); while (!req_bus.ready);
		pending_results.push_back(quat_result(op, lq, rq));
		gap = pick_gap(tx_idle_pct);
		if (gap > 0) begin
			req_bus.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	function automatic qau_pkg::val_t rand_part();
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return qau_pkg::val_t'($urandom);
			4, 5, 6, 7:
				return qau_pkg::val_t'($urandom_range(0, 1 << 20)) - qau_pkg::val_t'(1 << 19);
			8: case ($urandom_range(0, 4))
				0: return qau_pkg::VMAX;
				1: return qau_pkg::VMIN;
				2: return '0;
				3: return qau_pkg::val_t'(ONE_Q);
				default: return -qau_pkg::val_t'(ONE_Q);
			endcase
			default: return qau_pkg::val_t'($urandom_range(0, 6)) - qau_pkg::val_t'(3);
		endcase
	endfunction

	task automatic send_random(input int count);
		part4_t lq, rq;
		logic [qau_pkg::OPW-1:0] op;
		for (int n = 0; n < count; n++) begin
			for (int i = 0; i < 4; i++) begin
				lq[i] = rand_part();
				rq[i] = rand_part();
			end
			// an all-zero operand now and then for the zero divisor path
			if ($urandom_range(0, 19) == 0) lq = '{default: '0};
			if ($urandom_range(0, 19) == 0) rq = '{default: '0};
			if ($urandom_range(0, 19) == 0)
				op = qau_pkg::OPW'($urandom_range(OP_BAD_LO, OP_BAD_HI));
			else
				op = qau_pkg::OPW'($urandom_range(qau_pkg::OP_ADD, qau_pkg::OP_CHEB));
			send_beat(op, lq, rq);
		end
	endtask

	// ---------------- response side ----------------

	task automatic check_field(input string name, input qau_pkg::val_t want,
			input qau_pkg::val_t got);
		if (want !== got) begin
			err_count++;
			$display("%0t: %s mismatch, expected %0d got %0d", $time, name, want, got);
		end
	endtask

	initial begin
		qres_t want;
		int gap;
		rsp_bus.ready <= 1'b0;
		gap = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (rsp_bus.valid && rsp_bus.ready) begin
				if (pending_results.size() == 0) begin
					err_count++;
					$display("%0t: result beat with nothing outstanding", $time);
				end else begin
					want = pending_results.pop_front();
					check_field("out_real", want.re, rsp_bus.out_real);
					check_field("out_i", want.vi, rsp_bus.out_i);
					check_field("out_j", want.vj, rsp_bus.out_j);
					check_field("out_k", want.vk, rsp_bus.out_k);
					check_field("out_scalar", want.sc, rsp_bus.out_scalar);
					check_field("zero_divisor", qau_pkg::val_t'(want.zd),
						qau_pkg::val_t'(rsp_bus.zero_divisor));
					check_field("saturated", qau_pkg::val_t'(want.clip),
						qau_pkg::val_t'(rsp_bus.saturated));
				end
			end
			if (rx_hold_cycles > 0) begin
				rx_hold_cycles--;
				rsp_bus.ready <= 1'b0;
			end else if (gap > 0) begin
				gap--;
				rsp_bus.ready <= 1'b0;
			end else begin
				gap = pick_gap(rx_idle_pct);
				rsp_bus.ready <= (gap == 0);
				if (gap > 0) gap--;
			end
		end
	end

	always @(posedge clk) begin
		if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
			dog_count <= 0;
		else
			dog_count <= dog_count + 1;
		if (dog_count == DOG_LIMIT) begin
			$display("testbench failed");
			$finish;
		end
	end

	// ---------------- tests ----------------

	task automatic test_corner_cases();
		part4_t pmax, pmin, zq, unit, tiny, two, lsb, mix;
		pmax = '{default: qau_pkg::VMAX};
		pmin = '{default: qau_pkg::VMIN};
		zq   = '{default: '0};
		unit = '{qau_pkg::val_t'(ONE_Q), '0, '0, '0};
		tiny = '{'0, '0, '0, qau_pkg::val_t'(1)};
		two  = '{qau_pkg::val_t'(2 * ONE_Q), '0, '0, '0};
		lsb  = '{'0, qau_pkg::val_t'(1), '0, '0};
		mix  = '{qau_pkg::val_t'(ONE_Q), -qau_pkg::val_t'(2 * ONE_Q),
			qau_pkg::val_t'(3 * ONE_Q), qau_pkg::val_t'(ONE_Q / 2)};
		tx_idle_pct = 30;
		rx_idle_pct = 30;
		send_beat(qau_pkg::OP_ADD, pmax, pmax);
		send_beat(qau_pkg::OP_ADD, pmin, pmin);
		send_beat(qau_pkg::OP_SUB, pmin, pmax);
		send_beat(qau_pkg::OP_MUL, pmax, pmax);
		send_beat(qau_pkg::OP_MUL, pmin, pmin);
		send_beat(qau_pkg::OP_MUL, mix, mix);
		send_beat(qau_pkg::OP_DIV, mix, zq);
		send_beat(qau_pkg::OP_DIV, mix, unit);
		send_beat(qau_pkg::OP_DIV, pmax, tiny);
		send_beat(qau_pkg::OP_INV, zq, mix);
		send_beat(qau_pkg::OP_INV, two, zq);
		send_beat(qau_pkg::OP_INV, tiny, zq);
		send_beat(qau_pkg::OP_NRMZ, zq, zq);
		send_beat(qau_pkg::OP_NRMZ, lsb, zq);
		send_beat(qau_pkg::OP_NRMZ, pmax, zq);
		send_beat(qau_pkg::OP_CONJ, pmin, zq);
		send_beat(qau_pkg::OP_NORM, pmax, zq);
		send_beat(qau_pkg::OP_NORM, pmin, zq);
		send_beat(qau_pkg::OP_DOT, pmax, pmax);
		send_beat(qau_pkg::OP_DOT, pmin, pmax);
		send_beat(qau_pkg::OP_DIST, pmax, pmin);
		send_beat(qau_pkg::OP_CHEB, pmax, pmin);
		send_beat(OP_BAD_LO, pmax, pmin);
		send_beat(OP_BAD_HI, mix, mix);
	endtask

	task automatic test_random_traffic();
		tx_idle_pct = 25;
		rx_idle_pct = 25;
		send_random(550);
	endtask

	task automatic test_full_rate();
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		send_random(250);
	endtask

	// sink stalls while the source keeps offering, so the pipe backs up
	task automatic test_backpressure();
		tx_idle_pct = 0;
		rx_idle_pct = 10;
		rx_hold_cycles = STALL_HOLD;
		send_random(200);
	endtask

	initial begin
		err_count      = 0;
		tx_idle_pct    = 0;
		rx_idle_pct    = 0;
		rx_hold_cycles = 0;
		arst_n         = 1'b0;
		req_bus.valid      <= 1'b0;
		req_bus.op         <= qau_pkg::OP_ADD;
		req_bus.left_real  <= '0;
		req_bus.left_i     <= '0;
		req_bus.left_j     <= '0;
		req_bus.left_k     <= '0;
		req_bus.right_real <= '0;
		req_bus.right_i    <= '0;
		req_bus.right_j    <= '0;
		req_bus.right_k    <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_corner_cases();
		test_random_traffic();
		test_full_rate();
		test_backpressure();

		req_bus.valid <= 1'b0;
		wait (pending_results.size() == 0);
		repeat (SETTLE) @(posedge clk);
		if (err_count == 0)
			$display("testbench passed");
		else
			$display("testbench failed");
		$finish;
	end

endmodule

FILE: files.f
sv/qau_pkg.sv
sv/qau_in_if.sv
sv/qau_out_if.sv
sv/qau_front.sv
sv/qau_queue.sv
sv/qau_sqrt.sv
sv/qau_div.sv
sv/qau_back.sv
sv/quaternion_arithmetic_unit.sv
bench/testbench.sv
